>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ALE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ale assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define ALE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ale assertion failed");

`endif

>>> rtl/ale_pkg.sv
`timescale 1ns / 1ps

package ale_pkg;

  // Operation codes carried in req_t.func
  localparam logic [2:0] FN_APPEND   = 3'd0;
  localparam logic [2:0] FN_REM_LAST = 3'd1;
  localparam logic [2:0] FN_REM_AT   = 3'd2;
  localparam logic [2:0] FN_FIND     = 3'd3;
  localparam logic [2:0] FN_FIND_REM = 3'd4;
  localparam logic [2:0] FN_READ     = 3'd5;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // Request item
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
    logic [6:0]         position;
  } req_t;

  // Result item
  typedef struct packed {
    logic [2:0]         status;
    logic [6:0]         found_index;
    logic signed [31:0] read_value;
    logic [7:0]         entry_count;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;        // capture the request
    logic       append;      // write value at count, count + 1
    logic       dec;         // count - 1
    logic       scan_init;   // walk pointer to zero
    logic       scan;        // one search step
    logic       shift_init;  // walk pointer to base + 1
    logic       from_match;  // shift base is the matched entry, else position
    logic       shift;       // one gap-closing step
    logic       take_match;  // latch the matched index
    logic       read_pos;    // read the entry at position
    logic       post;        // load the result register
    logic [2:0] status;
    logic       show_idx;
    logic       show_rd;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_bad;
    logic hit;
    logic drained;   // walk done and no read in flight
  } dp_stat_t;

endpackage

>>> rtl/ale_datapath.sv
`timescale 1ns / 1ps

module ale_datapath #(
  parameter int LIST_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  ale_pkg::req_t     req,
  input  ale_pkg::dp_cmd_t  cmd,
  output ale_pkg::dp_stat_t stat,
  output ale_pkg::rsp_t     rsp
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  ale_pkg::req_t      req_q;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      rd_addr;
  logic               rd_pend;
  logic signed [31:0] rd_data;
  logic [CW-1:0]      match_idx;
  logic signed [31:0] mem [LIST_DEPTH];

  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic signed [31:0] mem_wd;
  logic               mem_re;
  logic [AW-1:0]      mem_ra;
  logic [CW-1:0]      shift_wa;
  logic [CW-1:0]      pos_cw;
  logic [CW-1:0]      shift_base;
  logic               walk;
  logic               more;

  assign pos_cw     = CW'(req_q.position);
  assign shift_base = cmd.from_match ? rd_addr : pos_cw;
  assign shift_wa   = rd_addr - CW'(1);
  assign walk       = cmd.scan || cmd.shift;
  assign more       = idx < count;

  // Status back to the controller
  assign stat.full    = count >= CW'(LIST_DEPTH);
  assign stat.empty   = count == '0;
  assign stat.pos_bad = PW'(req_q.position) >= PW'(count);
  assign stat.hit     = rd_pend && (rd_data == req_q.value);
  assign stat.drained = !rd_pend && !more;

  // Memory port control: append or shift write, one read per cycle
  always_comb begin
    mem_we = cmd.append || (cmd.shift && rd_pend);
    mem_wa = cmd.append ? count[AW-1:0] : shift_wa[AW-1:0];
    mem_wd = cmd.append ? req_q.value : rd_data;
    mem_re = cmd.read_pos || (walk && more);
    mem_ra = cmd.read_pos ? pos_cw[AW-1:0] : idx[AW-1:0];
  end

  // Entry memory with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  // Count and walk pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      idx     <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (cmd.append) begin
        count <= count + CW'(1);
      end else if (cmd.dec) begin
        count <= count - CW'(1);
      end
      if (cmd.scan_init) begin
        idx     <= '0;
        rd_pend <= 1'b0;
      end else if (cmd.shift_init) begin
        idx     <= shift_base + CW'(1);
        rd_pend <= 1'b0;
      end else if (walk) begin
        rd_pend <= more;
        if (more) begin
          idx <= idx + CW'(1);
        end
      end
    end
  end

  // Request, read address in flight, match index, result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (walk && more) begin
      rd_addr <= idx;
    end
    if (cmd.take_match) begin
      match_idx <= rd_addr;
    end
    if (cmd.post) begin
      rsp.status      <= cmd.status;
      rsp.found_index <= cmd.show_idx ? 7'(match_idx) : 7'd0;
      rsp.read_value  <= cmd.show_rd ? rd_data : 32'sd0;
      rsp.entry_count <= 8'(count);
    end
  end

endmodule

>>> rtl/ale_ctrl.sv
`timescale 1ns / 1ps

module ale_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [2:0]        req_func,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  ale_pkg::dp_stat_t stat,
  output ale_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_POST
  } state_t;

  state_t     state, state_next;
  logic [2:0] func_q, func_q_next;
  logic [2:0] st_code, st_code_next;
  logic       show_idx, show_idx_next;
  logic       show_rd, show_rd_next;
  logic       rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next     = state;
    func_q_next    = func_q;
    st_code_next   = st_code;
    show_idx_next  = show_idx;
    show_rd_next   = show_rd;
    rsp_valid_next = rsp_valid && !rsp_ready;
    cmd            = '0;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load    = 1'b1;
          func_q_next = req_func;
          state_next  = S_EXEC;
        end
      end

      S_EXEC: begin
        st_code_next  = ale_pkg::ST_OK;
        show_idx_next = 1'b0;
        show_rd_next  = 1'b0;
        state_next    = S_POST;
        case (func_q)
          ale_pkg::FN_APPEND: begin
            if (stat.full) st_code_next = ale_pkg::ST_FULL;
            else cmd.append = 1'b1;
          end
          ale_pkg::FN_REM_LAST: begin
            if (stat.empty) st_code_next = ale_pkg::ST_EMPTY;
            else cmd.dec = 1'b1;
          end
          ale_pkg::FN_REM_AT: begin
            if (stat.empty) begin
              st_code_next = ale_pkg::ST_EMPTY;
            end else if (stat.pos_bad) begin
              st_code_next = ale_pkg::ST_RANGE;
            end else begin
              cmd.shift_init = 1'b1;
              state_next     = S_SHIFT;
            end
          end
          ale_pkg::FN_FIND: begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
          ale_pkg::FN_FIND_REM: begin
            if (stat.empty) begin
              st_code_next = ale_pkg::ST_EMPTY;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          ale_pkg::FN_READ: begin
            if (stat.empty) begin
              st_code_next = ale_pkg::ST_EMPTY;
            end else if (stat.pos_bad) begin
              st_code_next = ale_pkg::ST_RANGE;
            end else begin
              cmd.read_pos = 1'b1;
              show_rd_next = 1'b1;
            end
          end
          default: begin
            st_code_next = ale_pkg::ST_OK;
          end
        endcase
      end

      // One entry compared per cycle, reads run one ahead
      S_SCAN: begin
        if (stat.hit) begin
          cmd.take_match = 1'b1;
          show_idx_next  = 1'b1;
          if (func_q == ale_pkg::FN_FIND_REM) begin
            cmd.shift_init = 1'b1;
            cmd.from_match = 1'b1;
            state_next     = S_SHIFT;
          end else begin
            state_next = S_POST;
          end
        end else if (stat.drained) begin
          st_code_next = ale_pkg::ST_NOTFOUND;
          state_next   = S_POST;
        end else begin
          cmd.scan = 1'b1;
        end
      end

      // Move later entries down one place, then drop the count
      S_SHIFT: begin
        if (stat.drained) begin
          cmd.dec    = 1'b1;
          state_next = S_POST;
        end else begin
          cmd.shift = 1'b1;
        end
      end

      S_POST: begin
        cmd.status   = st_code;
        cmd.show_idx = show_idx;
        cmd.show_rd  = show_rd;
        if (!rsp_valid || rsp_ready) begin
          cmd.post       = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      func_q    <= ale_pkg::FN_APPEND;
      st_code   <= ale_pkg::ST_OK;
      show_idx  <= 1'b0;
      show_rd   <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      func_q    <= func_q_next;
      st_code   <= st_code_next;
      show_idx  <= show_idx_next;
      show_rd   <= show_rd_next;
    end
  end

endmodule

>>> rtl/array_list_engine_top.sv
`timescale 1ns / 1ps
// Packed list of signed 32-bit entries with an entry count.
// Request channel (req_valid/req_ready/req) carries one operation item:
// append, remove last, remove at position, find, find and remove, read.
// Response channel (rsp_valid/rsp_ready/rsp) returns exactly one item per
// request: status, found index, read value and the count afterwards.
// One request is worked at a time; req_ready is high only when idle, and a
// new request can be taken in the cycle after the previous result is posted.
// From accept, each request passes S_EXEC and then S_POST before rsp_valid
// rises; find and find and remove first walk the entries in S_SCAN, and
// remove at position and find and remove close the gap in S_SHIFT.
// The walks go one entry per cycle through the single read port of the
// entry memory.
// The result sits in an output register; a stalled receiver holds it there
// and the next result waits in its final state until the register frees up.
// Reset (rst, synchronous) empties the list; entry contents are not cleared.
module array_list_engine_top #(
  parameter int LIST_DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ale_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ale_pkg::rsp_t rsp
);

  ale_pkg::dp_cmd_t  cmd;
  ale_pkg::dp_stat_t stat;

  ale_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_func  (req.func),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ale_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

>>> rtl/ale_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ale_checker #(
  parameter int LIST_DEPTH = 128
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input ale_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ale_pkg::rsp_t rsp
);

  // A stalled result holds
  `ALE_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

  // One item in work at a time
  `ALE_ASSERT_NXT(a_one_item, req_valid && req_ready, !req_ready)

  // Failed operations report no index and no data
  `ALE_ASSERT_IMP(a_fail_clean, rsp_valid && (rsp.status != ale_pkg::ST_OK), (rsp.found_index == 7'd0) && (rsp.read_value == 32'sd0))

  // Status is a defined code
  `ALE_ASSERT_IMP(a_status_code, rsp_valid, rsp.status <= ale_pkg::ST_NOTFOUND)

  // Count never passes the depth
  `ALE_ASSERT_IMP(a_count_max, rsp_valid && (LIST_DEPTH < 256), rsp.entry_count <= 8'(LIST_DEPTH))

endmodule

bind array_list_engine_top ale_checker #(.LIST_DEPTH(LIST_DEPTH)) u_ale_checker (.*);
